// ----- hw/rtl/intel_hex_record_encoder_assert.svh -----
// Assertion macros for the Intel HEX record encoder checker.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef INTEL_HEX_RECORD_ENCODER_ASSERT_SVH
`define INTEL_HEX_RECORD_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define IHEX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define IHEX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ihex_pkg.sv -----
// Shared types, constants and the microcode ROM of the Intel HEX encoder.
// No dependencies; used by the sequencer, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package ihex_pkg;

  localparam int ADDR_W             = 32;
  localparam int FILL_W             = 5;
  localparam int LINE_DEPTH         = 16;
  localparam int LINE_AW            = $clog2(LINE_DEPTH);
  localparam int BYTES_PER_LINE_DEF = 16;

  localparam logic [ADDR_W-1:0] LINE_MASK    = 32'h0000000F;
  localparam logic [ADDR_W-1:0] ADDR_LO_MASK = 32'h0000FFFF;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_A    = 8'h41;
  localparam logic [7:0] CHR_COLON  = 8'h3A;
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] REC_DATA   = 8'h00;
  localparam logic [7:0] REC_EXT    = 8'h04;
  localparam logic [7:0] EXT_COUNT  = 8'h02;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;

  localparam int TAIL_LEN = 11;
  localparam logic [8*TAIL_LEN-1:0] TAIL_STR = ":00000001FF";

  localparam int STEP_W = 6;
  typedef logic [STEP_W-1:0] step_t;

  // Program layout
  localparam step_t S_WAIT     = step_t'(0);
  localparam step_t S_DISPATCH = step_t'(1);
  localparam step_t S_EXT      = step_t'(2);
  localparam step_t S_EXT_LF   = step_t'(18);
  localparam step_t S_CHK      = step_t'(19);
  localparam step_t S_DATA     = step_t'(20);
  localparam step_t S_DHI      = step_t'(29);
  localparam step_t S_DLO      = step_t'(30);
  localparam step_t S_DAT_LF   = step_t'(34);
  localparam step_t S_TAIL     = step_t'(35);
  localparam step_t S_TAIL_END = step_t'(35 + TAIL_LEN - 1);

  typedef enum logic [1:0] {
    CS_LIT = 2'd0,
    CS_HI  = 2'd1,
    CS_LO  = 2'd2
  } chr_sel_t;

  typedef enum logic [2:0] {
    BS_LIT      = 3'd0,
    BS_FILL     = 3'd1,
    BS_LADDR_HI = 3'd2,
    BS_LADDR_LO = 3'd3,
    BS_EXT_HI   = 3'd4,
    BS_EXT_LO   = 3'd5,
    BS_DATA     = 3'd6,
    BS_CKSUM    = 3'd7
  } byte_sel_t;

  typedef enum logic [1:0] {
    LK_NONE     = 2'd0,
    LK_NO_CLOSE = 2'd1,
    LK_NO_LAST  = 2'd2,
    LK_ALWAYS   = 2'd3
  } last_kind_t;

  typedef enum logic [2:0] {
    J_NONE      = 3'd0,
    J_ALWAYS    = 3'd1,
    J_NO_ACCEPT = 3'd2,
    J_NO_EXT    = 3'd3,
    J_NO_CLOSE  = 3'd4,
    J_NO_LAST   = 3'd5,
    J_MORE      = 3'd6
  } jmp_t;

  typedef struct packed {
    logic       take;
    logic       emit;
    chr_sel_t   cs;
    byte_sel_t  bs;
    logic [7:0] lit;
    logic       sum_clr;
    logic       idx_inc;
    last_kind_t lk;
    jmp_t       jc;
    step_t      jt;
    logic       clr_fill;
    logic       reload;
  } ctl_t;

  typedef struct packed {
    logic accept;
    logic slot_free;
    logic ext;
    logic close;
    logic last;
    logic more;
  } status_t;

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    return (nib < 4'd10) ? ASCII_ZERO + {4'h0, nib} : ASCII_A + ({4'h0, nib} - 8'd10);
  endfunction

  function automatic ctl_t uc_lit(logic [7:0] ch);
    ctl_t c;
    c      = '0;
    c.emit = 1'b1;
    c.cs   = CS_LIT;
    c.lit  = ch;
    return c;
  endfunction

  function automatic ctl_t uc_hex(chr_sel_t cs, byte_sel_t bs, logic [7:0] lit);
    ctl_t c;
    c      = '0;
    c.emit = 1'b1;
    c.cs   = cs;
    c.bs   = bs;
    c.lit  = lit;
    return c;
  endfunction

  // Microcode ROM: one control word per step
  function automatic ctl_t ucode(step_t s);
    ctl_t c;
    int   off;
    c   = '0;
    off = int'(s) - int'(S_TAIL);
    case (s)
      S_WAIT: begin
        c.take = 1'b1;
        c.jc   = J_NO_ACCEPT;
        c.jt   = S_WAIT;
      end
      S_DISPATCH: begin
        c.jc = J_NO_EXT;
        c.jt = S_CHK;
      end
      // extended linear address record
      S_EXT: begin
        c         = uc_lit(CHR_COLON);
        c.sum_clr = 1'b1;
      end
      S_EXT + 1:  c = uc_hex(CS_HI, BS_LIT, EXT_COUNT);
      S_EXT + 2:  c = uc_hex(CS_LO, BS_LIT, EXT_COUNT);
      S_EXT + 3:  c = uc_hex(CS_HI, BS_LIT, ZERO_BYTE);
      S_EXT + 4:  c = uc_hex(CS_LO, BS_LIT, ZERO_BYTE);
      S_EXT + 5:  c = uc_hex(CS_HI, BS_LIT, ZERO_BYTE);
      S_EXT + 6:  c = uc_hex(CS_LO, BS_LIT, ZERO_BYTE);
      S_EXT + 7:  c = uc_hex(CS_HI, BS_LIT, REC_EXT);
      S_EXT + 8:  c = uc_hex(CS_LO, BS_LIT, REC_EXT);
      S_EXT + 9:  c = uc_hex(CS_HI, BS_EXT_HI, ZERO_BYTE);
      S_EXT + 10: c = uc_hex(CS_LO, BS_EXT_HI, ZERO_BYTE);
      S_EXT + 11: c = uc_hex(CS_HI, BS_EXT_LO, ZERO_BYTE);
      S_EXT + 12: c = uc_hex(CS_LO, BS_EXT_LO, ZERO_BYTE);
      S_EXT + 13: c = uc_hex(CS_HI, BS_CKSUM, ZERO_BYTE);
      S_EXT + 14: c = uc_hex(CS_LO, BS_CKSUM, ZERO_BYTE);
      S_EXT + 15: c = uc_lit(CHR_CR);
      S_EXT_LF: begin
        c    = uc_lit(CHR_LF);
        c.lk = LK_NO_CLOSE;
        c.jc = J_NO_CLOSE;
        c.jt = S_WAIT;
      end
      S_CHK: begin
        c.jc = J_NO_CLOSE;
        c.jt = S_WAIT;
      end
      // data record
      S_DATA: begin
        c         = uc_lit(CHR_COLON);
        c.sum_clr = 1'b1;
      end
      S_DATA + 1: c = uc_hex(CS_HI, BS_FILL, ZERO_BYTE);
      S_DATA + 2: c = uc_hex(CS_LO, BS_FILL, ZERO_BYTE);
      S_DATA + 3: c = uc_hex(CS_HI, BS_LADDR_HI, ZERO_BYTE);
      S_DATA + 4: c = uc_hex(CS_LO, BS_LADDR_HI, ZERO_BYTE);
      S_DATA + 5: c = uc_hex(CS_HI, BS_LADDR_LO, ZERO_BYTE);
      S_DATA + 6: c = uc_hex(CS_LO, BS_LADDR_LO, ZERO_BYTE);
      S_DATA + 7: c = uc_hex(CS_HI, BS_LIT, REC_DATA);
      S_DATA + 8: c = uc_hex(CS_LO, BS_LIT, REC_DATA);
      S_DHI:      c = uc_hex(CS_HI, BS_DATA, ZERO_BYTE);
      S_DLO: begin
        c         = uc_hex(CS_LO, BS_DATA, ZERO_BYTE);
        c.idx_inc = 1'b1;
        c.jc      = J_MORE;
        c.jt      = S_DHI;
      end
      S_DATA + 11: c = uc_hex(CS_HI, BS_CKSUM, ZERO_BYTE);
      S_DATA + 12: c = uc_hex(CS_LO, BS_CKSUM, ZERO_BYTE);
      S_DATA + 13: c = uc_lit(CHR_CR);
      S_DAT_LF: begin
        c          = uc_lit(CHR_LF);
        c.lk       = LK_NO_LAST;
        c.clr_fill = 1'b1;
        c.jc       = J_NO_LAST;
        c.jt       = S_WAIT;
      end
      // end-of-file record, no CR LF
      S_TAIL_END: begin
        c        = uc_lit(TAIL_STR[7:0]);
        c.lk     = LK_ALWAYS;
        c.reload = 1'b1;
        c.jc     = J_ALWAYS;
        c.jt     = S_WAIT;
      end
      default: begin
        if (s >= S_TAIL && s < S_TAIL_END) begin
          c = uc_lit(TAIL_STR[8*(TAIL_LEN-1-off) +: 8]);
        end else begin
          c.jc = J_ALWAYS;
          c.jt = S_WAIT;
        end
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ihex_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ihex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/ihex_useq.sv -----
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on ihex_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ihex_useq (
  input  logic              clk,
  input  logic              rst_n,
  input  ihex_pkg::status_t st,
  output ihex_pkg::ctl_t    ctl,
  output logic              adv
);

  ihex_pkg::step_t step_r;
  ihex_pkg::step_t step_nxt;
  logic            jump;

  assign ctl = ihex_pkg::ucode(step_r);
  // emitting steps wait for a free output slot
  assign adv = !ctl.emit || st.slot_free;

  always_comb begin
    case (ctl.jc)
      ihex_pkg::J_NONE:      jump = 1'b0;
      ihex_pkg::J_ALWAYS:    jump = 1'b1;
      ihex_pkg::J_NO_ACCEPT: jump = !st.accept;
      ihex_pkg::J_NO_EXT:    jump = !st.ext;
      ihex_pkg::J_NO_CLOSE:  jump = !st.close;
      ihex_pkg::J_NO_LAST:   jump = !st.last;
      ihex_pkg::J_MORE:      jump = st.more;
      default:               jump = 1'b1;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (adv) begin
      step_nxt = jump ? ctl.jt : step_r + ihex_pkg::step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ihex_pkg::S_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ihex_dp.sv -----
// Encoder datapath: address and line state, line buffer, checksum, output register.
// Depends on ihex_pkg and ihex_ram; driven by the control word of ihex_useq.
`timescale 1ns / 1ps
`default_nettype none

module ihex_dp #(
  parameter int BYTES_PER_LINE = ihex_pkg::BYTES_PER_LINE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [ihex_pkg::ADDR_W-1:0] cfg_start_address,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_last_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_char,
  output logic                        out_last_of_run,
  input  ihex_pkg::ctl_t              ctl,
  input  logic                        adv,
  output ihex_pkg::status_t           st
);

  localparam int FW = ihex_pkg::FILL_W;
  localparam int AW = ihex_pkg::ADDR_W;

  logic [AW-1:0] start_r;
  logic [AW-1:0] cur_r;
  logic [AW-1:0] line_addr_r;
  logic [FW-1:0] fill_r;
  logic [FW-1:0] idx_r;
  logic [FW-1:0] idx_nxt;
  logic [7:0]    sum_r;
  logic          ext_pend_r;
  logic          open_r;
  logic          ext_r;
  logic          close_r;
  logic          last_r;
  logic          out_valid_r;
  logic [7:0]    out_char_r;
  logic          out_last_r;

  logic          accept;
  logic          need_ext;
  logic          close_now;
  logic [FW-1:0] fill_inc;
  logic [AW-1:0] cur_inc;
  logic [7:0]    rd_data;
  logic [7:0]    byte_val;
  logic [7:0]    chr_val;
  logic          last_val;

  assign in_ready = ctl.take;
  assign accept   = in_valid && ctl.take;

  assign fill_inc  = fill_r + FW'(1);
  assign cur_inc   = cur_r + AW'(1);
  // extended record: first line of a high stream, or line opens on a 64 KiB boundary
  assign need_ext  = (fill_r == '0) && (ext_pend_r || ((cur_r & ihex_pkg::ADDR_LO_MASK) == '0));
  assign close_now = in_last_byte || ((cur_inc & ihex_pkg::LINE_MASK) == '0) ||
                     ({1'b0, fill_inc} >= (FW+1)'(BYTES_PER_LINE)) ||
                     (fill_inc >= FW'(ihex_pkg::LINE_DEPTH));

  always_comb begin
    idx_nxt = idx_r;
    if (adv && ctl.sum_clr) begin
      idx_nxt = '0;
    end else if (adv && ctl.idx_inc) begin
      idx_nxt = idx_r + FW'(1);
    end
  end

  // read address runs one step ahead so rd_data matches idx_r
  ihex_ram #(
    .WIDTH (8),
    .DEPTH (ihex_pkg::LINE_DEPTH)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (fill_r[ihex_pkg::LINE_AW-1:0]),
    .wr_data (in_data_byte),
    .rd_addr (idx_nxt[ihex_pkg::LINE_AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    case (ctl.bs)
      ihex_pkg::BS_LIT:      byte_val = ctl.lit;
      ihex_pkg::BS_FILL:     byte_val = 8'(fill_r);
      ihex_pkg::BS_LADDR_HI: byte_val = line_addr_r[15:8];
      ihex_pkg::BS_LADDR_LO: byte_val = line_addr_r[7:0];
      ihex_pkg::BS_EXT_HI:   byte_val = line_addr_r[31:24];
      ihex_pkg::BS_EXT_LO:   byte_val = line_addr_r[23:16];
      ihex_pkg::BS_DATA:     byte_val = rd_data;
      ihex_pkg::BS_CKSUM:    byte_val = 8'h00 - sum_r;
      default:               byte_val = ctl.lit;
    endcase
  end

  always_comb begin
    case (ctl.cs)
      ihex_pkg::CS_LIT: chr_val = ctl.lit;
      ihex_pkg::CS_HI:  chr_val = ihex_pkg::hex_char(byte_val[7:4]);
      ihex_pkg::CS_LO:  chr_val = ihex_pkg::hex_char(byte_val[3:0]);
      default:          chr_val = ctl.lit;
    endcase
  end

  always_comb begin
    case (ctl.lk)
      ihex_pkg::LK_NONE:     last_val = 1'b0;
      ihex_pkg::LK_NO_CLOSE: last_val = !close_r;
      ihex_pkg::LK_NO_LAST:  last_val = !last_r;
      ihex_pkg::LK_ALWAYS:   last_val = 1'b1;
      default:               last_val = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '0;
      cur_r       <= '0;
      line_addr_r <= '0;
      fill_r      <= '0;
      idx_r       <= '0;
      sum_r       <= '0;
      ext_pend_r  <= 1'b0;
      open_r      <= 1'b0;
      ext_r       <= 1'b0;
      close_r     <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        open_r  <= 1'b1;
        ext_r   <= need_ext;
        close_r <= close_now;
        last_r  <= in_last_byte;
        fill_r  <= fill_inc;
        cur_r   <= cur_inc;
        if (fill_r == '0) begin
          line_addr_r <= cur_r;
        end
        if (need_ext) begin
          ext_pend_r <= 1'b0;
        end
      end
      if (adv && ctl.clr_fill) begin
        fill_r <= '0;
      end
      if (adv && ctl.reload) begin
        cur_r      <= start_r;
        ext_pend_r <= start_r > ihex_pkg::ADDR_LO_MASK;
        fill_r     <= '0;
        open_r     <= 1'b0;
      end
      if (cfg_wr_en) begin
        start_r <= cfg_start_address;
        if (!open_r) begin
          cur_r      <= cfg_start_address;
          ext_pend_r <= cfg_start_address > ihex_pkg::ADDR_LO_MASK;
          fill_r     <= '0;
        end
      end
      idx_r <= idx_nxt;
      if (adv && ctl.sum_clr) begin
        sum_r <= '0;
      end else if (adv && ctl.emit && (ctl.cs == ihex_pkg::CS_LO)) begin
        sum_r <= sum_r + byte_val;
      end
      if (adv && ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl.emit) begin
      out_char_r <= chr_val;
      out_last_r <= last_val;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_last_of_run = out_last_r;

  assign st.accept    = accept;
  assign st.slot_free = !out_valid_r || out_ready;
  assign st.ext       = ext_r;
  assign st.close     = close_r;
  assign st.last      = last_r;
  assign st.more      = (idx_r + FW'(1)) != fill_r;

endmodule

`default_nettype wire

// ----- hw/rtl/intel_hex_record_encoder.sv -----
// Top level of the Intel HEX (I32HEX) record encoder: sequencer plus datapath.
// Depends on ihex_pkg, ihex_useq, ihex_dp (and ihex_ram through ihex_dp).
//
//   channel  direction  handshake           payload
//   in_      sink       in_valid/in_ready   in_data_byte[7:0], in_last_byte
//   out_     source     out_valid/out_ready out_char[7:0], out_last_of_run
//   cfg_     sink       cfg_wr_en           cfg_start_address[31:0]
//
// A byte that closes no line passes the take, dispatch and close check steps.
// A line-opening byte that needs an extended address record adds that 17-character
// record; a closing byte adds an n-byte data record of 13 + 2*n characters and, for
// the last byte, the 11-character end record (56 characters max per byte).
// Each emitting step waits while the output register is full and out_ready is low.
// in_ready is high only in the take step.
// rst_n is synchronous; the line buffer needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module intel_hex_record_encoder #(
  parameter int BYTES_PER_LINE = ihex_pkg::BYTES_PER_LINE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [ihex_pkg::ADDR_W-1:0] cfg_start_address,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_last_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_char,
  output logic                        out_last_of_run
);

  ihex_pkg::ctl_t    ctl;
  ihex_pkg::status_t st;
  logic              adv;

  ihex_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .ctl   (ctl),
    .adv   (adv)
  );

  ihex_dp #(
    .BYTES_PER_LINE (BYTES_PER_LINE)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_start_address (cfg_start_address),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char          (out_char),
    .out_last_of_run   (out_last_of_run),
    .ctl               (ctl),
    .adv               (adv),
    .st                (st)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ihex_chk.sv -----
// Port-level checker for the Intel HEX record encoder, bound to the top level.
// Depends on intel_hex_record_encoder_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "intel_hex_record_encoder_assert.svh"

module ihex_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_char,
  input wire logic        out_last_of_run
);

  // stalled result holds
  `IHEX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(out_last_of_run), "result changed while stalled")
  // one byte at a time: a transfer is never followed directly by another
  `IHEX_ASSERT_NEXT(a_in_busy, in_valid && in_ready, !in_ready, "input taken while busy")
  // a run ends on LF of a record or on the final F of the end record
  `IHEX_ASSERT_NOW(a_run_end, out_valid && out_last_of_run, out_char == 8'h0A || out_char == 8'h46, "bad end-of-run character")
  // a record start never ends a run
  `IHEX_ASSERT_NOW(a_colon, out_valid && out_char == 8'h3A, !out_last_of_run, "run ended on record start")

endmodule

bind intel_hex_record_encoder ihex_chk u_ihex_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_char        (out_char),
  .out_last_of_run (out_last_of_run)
);

`default_nettype wire
